[src/c25fa_pkg.sv]
// ----------------------------------------------------------------------------
// c25fa_pkg: shared types and constants of the field arithmetic unit
// Beat formats, sequencer states, opcode codes, the exponent-chain program
// and helper functions for limb handling modulo 2^255-19.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c25fa_pkg;

  localparam int NUM_LIMBS = 10;
  localparam int MEM_DEPTH = 80;

  localparam logic [63:0] LIMB_M26 = 64'h3FF_FFFF;
  localparam logic [63:0] LIMB_M25 = 64'h1FF_FFFF;

  localparam logic [3:0] OP_LOAD_A    = 4'd0;
  localparam logic [3:0] OP_LOAD_B    = 4'd1;
  localparam logic [3:0] OP_MUL       = 4'd2;
  localparam logic [3:0] OP_SQUARE    = 4'd3;
  localparam logic [3:0] OP_ADD       = 4'd4;
  localparam logic [3:0] OP_SUB       = 4'd5;
  localparam logic [3:0] OP_NEG       = 4'd6;
  localparam logic [3:0] OP_MUL_SMALL = 4'd7;
  localparam logic [3:0] OP_INVERT    = 4'd8;
  localparam logic [3:0] OP_POW22523  = 4'd9;
  localparam logic [3:0] OP_SELECT    = 4'd10;
  localparam logic [3:0] OP_CANON     = 4'd11;

  localparam logic [2:0] SLOT_A = 3'd0;
  localparam logic [2:0] SLOT_B = 3'd1;

  localparam logic [4:0] PC_MUL       = 5'd0;
  localparam logic [4:0] PC_SQUARE    = 5'd1;
  localparam logic [4:0] PC_CHAIN     = 5'd2;
  localparam logic [4:0] PC_CHAIN_END = 5'd21;
  localparam logic [4:0] PC_INV_TAIL  = 5'd22;
  localparam logic [4:0] PC_POW_TAIL  = 5'd24;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  word_index;
    logic [63:0] data_word;
    logic [31:0] small_factor;
    logic        select_bit;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic [1:0]  result_index;
    logic        last_word;
    logic        result_is_zero;
    logic        result_is_negative;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNPACK,
    ST_LIN,
    ST_CLEAR,
    ST_ISSUE,
    ST_DRAIN,
    ST_FOLD,
    ST_WB,
    ST_QCALC,
    ST_ADDQ,
    ST_CARRY,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    K_MAC,
    K_SMALL,
    K_ADD,
    K_SUB,
    K_NEG,
    K_PASS
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [3:0] col;
    logic       dbl;
    logic       x19;
  } mac_ctrl_t;

  typedef struct packed {
    logic [2:0] dst;
    logic [2:0] sx;
    logic [2:0] sy;
    logic [6:0] cnt;
    logic       last;
  } instr_t;

  function automatic instr_t mk_instr(input logic [2:0] d, input logic [2:0] s,
                                      input logic [2:0] t, input logic [6:0] n,
                                      input logic l);
    instr_t r;
    r.dst  = d;
    r.sx   = s;
    r.sy   = t;
    r.cnt  = n;
    r.last = l;
    return r;
  endfunction

  // Slot 6 holds the final product; slots 2 to 5 hold chain temporaries.
  function automatic instr_t prog_rom(input logic [4:0] pc);
    instr_t r;
    unique case (pc)
      5'd0:    r = mk_instr(3'd6, 3'd0, 3'd1, 7'd1,   1'b1);
      5'd1:    r = mk_instr(3'd6, 3'd0, 3'd0, 7'd1,   1'b1);
      5'd2:    r = mk_instr(3'd2, 3'd0, 3'd0, 7'd1,   1'b0);
      5'd3:    r = mk_instr(3'd3, 3'd2, 3'd2, 7'd2,   1'b0);
      5'd4:    r = mk_instr(3'd3, 3'd0, 3'd3, 7'd1,   1'b0);
      5'd5:    r = mk_instr(3'd4, 3'd2, 3'd3, 7'd1,   1'b0);
      5'd6:    r = mk_instr(3'd2, 3'd4, 3'd4, 7'd1,   1'b0);
      5'd7:    r = mk_instr(3'd2, 3'd3, 3'd2, 7'd1,   1'b0);
      5'd8:    r = mk_instr(3'd3, 3'd2, 3'd2, 7'd5,   1'b0);
      5'd9:    r = mk_instr(3'd3, 3'd2, 3'd3, 7'd1,   1'b0);
      5'd10:   r = mk_instr(3'd2, 3'd3, 3'd3, 7'd10,  1'b0);
      5'd11:   r = mk_instr(3'd2, 3'd3, 3'd2, 7'd1,   1'b0);
      5'd12:   r = mk_instr(3'd5, 3'd2, 3'd2, 7'd20,  1'b0);
      5'd13:   r = mk_instr(3'd5, 3'd2, 3'd5, 7'd1,   1'b0);
      5'd14:   r = mk_instr(3'd5, 3'd5, 3'd5, 7'd10,  1'b0);
      5'd15:   r = mk_instr(3'd3, 3'd3, 3'd5, 7'd1,   1'b0);
      5'd16:   r = mk_instr(3'd2, 3'd3, 3'd3, 7'd50,  1'b0);
      5'd17:   r = mk_instr(3'd2, 3'd3, 3'd2, 7'd1,   1'b0);
      5'd18:   r = mk_instr(3'd5, 3'd2, 3'd2, 7'd100, 1'b0);
      5'd19:   r = mk_instr(3'd5, 3'd2, 3'd5, 7'd1,   1'b0);
      5'd20:   r = mk_instr(3'd5, 3'd5, 3'd5, 7'd50,  1'b0);
      5'd21:   r = mk_instr(3'd5, 3'd3, 3'd5, 7'd1,   1'b0);
      5'd22:   r = mk_instr(3'd5, 3'd5, 3'd5, 7'd5,   1'b0);
      5'd23:   r = mk_instr(3'd6, 3'd4, 3'd5, 7'd1,   1'b1);
      5'd24:   r = mk_instr(3'd5, 3'd5, 3'd5, 7'd2,   1'b0);
      5'd25:   r = mk_instr(3'd6, 3'd0, 3'd5, 7'd1,   1'b1);
      default: r = mk_instr(3'd6, 3'd0, 3'd0, 7'd1,   1'b1);
    endcase
    return r;
  endfunction

  function automatic logic [27:0] bias4p(input logic [3:0] k);
    logic [27:0] r;
    if (k == 4'd0) begin
      r = 28'hFFF_FFB4;
    end else if (k[0]) begin
      r = 28'h7FF_FFFC;
    end else begin
      r = 28'hFFF_FFFC;
    end
    return r;
  endfunction

  function automatic logic [63:0] mul19(input logic [63:0] v);
    return (v << 4) + (v << 1) + v;
  endfunction

  function automatic logic [6:0] slot_addr(input logic [2:0] s, input logic [3:0] l);
    return 7'({s, 3'b000}) + 7'({s, 1'b0}) + 7'(l);
  endfunction

  function automatic logic [25:0] unpack_limb(input logic [255:0] w, input logic [3:0] l);
    logic [25:0] r;
    unique case (l)
      4'd0:    r = w[25:0];
      4'd1:    r = {1'b0, w[50:26]};
      4'd2:    r = w[76:51];
      4'd3:    r = {1'b0, w[101:77]};
      4'd4:    r = w[127:102];
      4'd5:    r = {1'b0, w[152:128]};
      4'd6:    r = w[178:153];
      4'd7:    r = {1'b0, w[203:179]};
      4'd8:    r = w[229:204];
      4'd9:    r = {1'b0, w[254:230]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/c25fa_mac.sv]
// ----------------------------------------------------------------------------
// c25fa_mac: shared multiply and limb arithmetic stage
// Registers one 26x32 product or one limb add, subtract, negate or pass per cycle
// and presents the term, doubled and scaled by 19 where the column needs it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c25fa_mac
  import c25fa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mac_ctrl_t   ctrl_i,
  input  logic [25:0] x_i,
  input  logic [25:0] y_i,
  input  logic [31:0] small_i,
  output mac_ctrl_t   ctrl_o,
  output logic [63:0] term_o
);

  mac_ctrl_t   ctrl_r;
  logic [57:0] prod_r, prod_nxt;
  logic [28:0] lin_r, lin_nxt;
  logic [31:0] mul_y;
  logic [58:0] p2;
  logic [63:0] p2w;

  always_comb begin
    mul_y    = (ctrl_i.kind == K_SMALL) ? small_i : {6'd0, y_i};
    prod_nxt = x_i * mul_y;
    unique case (ctrl_i.kind)
      K_ADD:   lin_nxt = 29'(x_i) + 29'(y_i);
      K_SUB:   lin_nxt = 29'(x_i) + 29'(bias4p(ctrl_i.col)) - 29'(y_i);
      K_NEG:   lin_nxt = 29'(bias4p(ctrl_i.col)) - 29'(x_i);
      K_PASS:  lin_nxt = 29'(x_i);
      default: lin_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    lin_r  <= lin_nxt;
  end

  always_comb begin
    p2  = ctrl_r.dbl ? {prod_r, 1'b0} : {1'b0, prod_r};
    p2w = {5'd0, p2};
    unique case (ctrl_r.kind)
      K_MAC:   term_o = ctrl_r.x19 ? mul19(p2w) : p2w;
      K_SMALL: term_o = {6'd0, prod_r};
      default: term_o = {35'd0, lin_r};
    endcase
  end

  assign ctrl_o = ctrl_r;

endmodule

`default_nettype wire

[src/curve25519_field_arith_unit.sv]
// ----------------------------------------------------------------------------
// curve25519_field_arith_unit: arithmetic modulo 2^255-19
// Loads two operands word by word and runs one field operation on ten
// 26/25-bit limbs through a shared multiplier, then emits the canonical result.
// ----------------------------------------------------------------------------
// Loads keep the unit ready. A run first unpacks both operands into limbs,
// then runs each limb multiply as 100 products through the one multiplier
// with a carry fold and write-back, and finishes with a final fold, a
// reduction and a carry pass; invert runs the whole exponent chain.
// The four result beats follow on consecutive cycles and cannot be stalled.
// Reset clears the sequencer and the limb accumulator; operands stay as they are.
`timescale 1ns / 1ps
`default_nettype none

module curve25519_field_arith_unit
  import c25fa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  state_t      state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [3:0]  i_r, i_nxt, j_r, j_nxt;
  logic [6:0]  iter_r, iter_nxt;
  logic [4:0]  pc_r, pc_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        sel_r, sel_nxt;
  logic [31:0] small_r, small_nxt;
  logic        final_r, final_nxt;
  logic [1:0]  q_r, q_nxt;

  logic [63:0] opa_r [4];
  logic [63:0] opb_r [4];
  logic [63:0] col_r [NUM_LIMBS];
  logic [63:0] col_nxt [NUM_LIMBS];

  logic [25:0] mem_r [MEM_DEPTH];
  logic [25:0] rdx_r, rdy_r;
  logic        mem_we;
  logic [6:0]  mem_waddr, raddr_x, raddr_y;
  logic [25:0] mem_wdata;

  mac_ctrl_t   ctrl0, ctrl1_r, ctrl2;
  logic [63:0] term;

  instr_t      instr;
  logic        in_accept, lin_op;
  logic [3:0]  limb;
  logic [3:0]  unpack_l;
  logic [2:0]  sx_eff, sy_eff, lin_x;
  logic [4:0]  ij_sum;
  logic [63:0] fold_c, fold_low, fold_add, qsum;
  logic [255:0] opa_cat, opb_cat;
  logic        all_zero;

  assign instr     = prog_rom(pc_r);
  assign in_accept = start && !busy;
  assign lin_op    = !(op_r == OP_MUL || op_r == OP_SQUARE || op_r == OP_INVERT ||
                       op_r == OP_POW22523);
  assign limb      = step_r[3:0];
  assign opa_cat   = {opa_r[3], opa_r[2], opa_r[1], opa_r[0]};
  assign opb_cat   = {opb_r[3], opb_r[2], opb_r[1], opb_r[0]};

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    iter_nxt  = iter_r;
    pc_nxt    = pc_r;
    op_nxt    = op_r;
    sel_nxt   = sel_r;
    small_nxt = small_r;
    final_nxt = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_data.opcode >= OP_MUL && in_data.opcode <= OP_CANON) begin
          op_nxt    = in_data.opcode;
          sel_nxt   = in_data.select_bit;
          small_nxt = in_data.small_factor;
          final_nxt = 1'b0;
          step_nxt  = '0;
          state_nxt = ST_UNPACK;
        end
      end
      ST_UNPACK: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd19) begin
          step_nxt = '0;
          iter_nxt = '0;
          if (lin_op) begin
            state_nxt = ST_LIN;
          end else begin
            state_nxt = ST_CLEAR;
            if (op_r == OP_MUL) begin
              pc_nxt = PC_MUL;
            end else if (op_r == OP_SQUARE) begin
              pc_nxt = PC_SQUARE;
            end else begin
              pc_nxt = PC_CHAIN;
            end
          end
        end
      end
      ST_LIN: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd9) begin
          step_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_CLEAR: begin
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (j_r == 4'd9) begin
          j_nxt = '0;
          if (i_r == 4'd9) begin
            step_nxt  = '0;
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 4'd1;
          end
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      ST_DRAIN: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd1) begin
          step_nxt  = '0;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd10) begin
          step_nxt = '0;
          if (final_r) begin
            state_nxt = ST_QCALC;
          end else if (lin_op) begin
            final_nxt = 1'b1;
            state_nxt = ST_FOLD;
          end else begin
            state_nxt = ST_WB;
          end
        end
      end
      ST_WB: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd9) begin
          step_nxt = '0;
          if (iter_r + 7'd1 < instr.cnt) begin
            iter_nxt  = iter_r + 7'd1;
            state_nxt = ST_CLEAR;
          end else if (instr.last) begin
            final_nxt = 1'b1;
            state_nxt = ST_FOLD;
          end else begin
            iter_nxt  = '0;
            state_nxt = ST_CLEAR;
            if (pc_r == PC_CHAIN_END) begin
              pc_nxt = (op_r == OP_POW22523) ? PC_POW_TAIL : PC_INV_TAIL;
            end else begin
              pc_nxt = pc_r + 5'd1;
            end
          end
        end
      end
      ST_QCALC: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd9) begin
          step_nxt  = '0;
          state_nxt = ST_ADDQ;
        end
      end
      ST_ADDQ: begin
        step_nxt  = '0;
        state_nxt = ST_CARRY;
      end
      ST_CARRY: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd9) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd3) begin
          step_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, memory controls and issue control.
  always_comb begin
    busy      = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    unpack_l  = (step_r < 5'd10) ? limb : 4'(step_r - 5'd10);
    mem_waddr = slot_addr((step_r < 5'd10) ? SLOT_A : SLOT_B, unpack_l);
    mem_wdata = unpack_limb((step_r < 5'd10) ? opa_cat : opb_cat, unpack_l);
    sx_eff    = (iter_r == 7'd0) ? instr.sx : instr.dst;
    sy_eff    = (iter_r == 7'd0) ? instr.sy : instr.dst;
    lin_x     = (op_r == OP_SELECT && sel_r) ? SLOT_B : SLOT_A;
    ij_sum    = {1'b0, i_r} + {1'b0, j_r};
    raddr_x   = slot_addr(sx_eff, i_r);
    raddr_y   = slot_addr(sy_eff, j_r);
    ctrl0     = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_UNPACK: mem_we = 1'b1;
      ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = slot_addr(instr.dst, limb);
        mem_wdata = col_r[0][25:0];
      end
      ST_ISSUE: begin
        ctrl0.valid = 1'b1;
        ctrl0.kind  = K_MAC;
        ctrl0.x19   = (ij_sum >= 5'd10);
        ctrl0.col   = (ij_sum >= 5'd10) ? 4'(ij_sum - 5'd10) : ij_sum[3:0];
        ctrl0.dbl   = i_r[0] & j_r[0];
      end
      ST_LIN: begin
        raddr_x     = slot_addr(lin_x, limb);
        raddr_y     = slot_addr(SLOT_B, limb);
        ctrl0.valid = 1'b1;
        ctrl0.col   = limb;
        if (op_r == OP_ADD) begin
          ctrl0.kind = K_ADD;
        end else if (op_r == OP_SUB) begin
          ctrl0.kind = K_SUB;
        end else if (op_r == OP_NEG) begin
          ctrl0.kind = K_NEG;
        end else if (op_r == OP_MUL_SMALL) begin
          ctrl0.kind = K_SMALL;
        end else begin
          ctrl0.kind = K_PASS;
        end
      end
      ST_EMIT: out_valid = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    all_zero = 1'b1;
    for (int n = 0; n < NUM_LIMBS; n++) begin
      if (col_r[n] != 64'd0) begin
        all_zero = 1'b0;
      end
    end
    out_data.result_index       = step_r[1:0];
    out_data.last_word          = (step_r[1:0] == 2'd3);
    out_data.result_is_zero     = all_zero;
    out_data.result_is_negative = col_r[0][0];
    unique case (step_r[1:0])
      2'd0: out_data.result_word = {col_r[2][12:0], col_r[1][24:0], col_r[0][25:0]};
      2'd1: out_data.result_word = {col_r[4][25:0], col_r[3][24:0], col_r[2][25:13]};
      2'd2: out_data.result_word = {col_r[7][12:0], col_r[6][25:0], col_r[5][24:0]};
      default: out_data.result_word = {1'b0, col_r[9][24:0], col_r[8][25:0],
                                       col_r[7][24:13]};
    endcase
  end

  // Limb accumulator: products land in their column; carries rotate the limbs
  // past position zero so each step touches fixed places only.
  always_comb begin
    fold_c   = limb[0] ? (col_r[0] >> 25) : (col_r[0] >> 26);
    fold_low = limb[0] ? (col_r[0] & LIMB_M25) : (col_r[0] & LIMB_M26);
    fold_add = fold_c;
    if (limb == 4'd9) begin
      fold_add = (state_r == ST_FOLD) ? mul19(fold_c) : 64'd0;
    end
    qsum  = (limb == 4'd0) ? (col_r[0] + 64'd19) : (col_r[0] + 64'(q_r));
    q_nxt = q_r;
    for (int n = 0; n < NUM_LIMBS; n++) begin
      col_nxt[n] = col_r[n];
    end
    unique case (state_r)
      ST_CLEAR: begin
        for (int n = 0; n < NUM_LIMBS; n++) begin
          col_nxt[n] = '0;
        end
      end
      ST_FOLD, ST_CARRY: begin
        if (limb == 4'd10) begin
          col_nxt[0] = col_r[0] & LIMB_M26;
          col_nxt[1] = col_r[1] + (col_r[0] >> 26);
        end else begin
          for (int n = 0; n < NUM_LIMBS - 1; n++) begin
            col_nxt[n] = col_r[n + 1];
          end
          col_nxt[0] = col_r[1] + fold_add;
          col_nxt[9] = fold_low;
        end
      end
      ST_QCALC, ST_WB: begin
        for (int n = 0; n < NUM_LIMBS - 1; n++) begin
          col_nxt[n] = col_r[n + 1];
        end
        col_nxt[9] = col_r[0];
        if (state_r == ST_QCALC) begin
          q_nxt = limb[0] ? 2'(qsum >> 25) : 2'(qsum >> 26);
        end
      end
      ST_ADDQ: col_nxt[0] = col_r[0] + mul19(64'(q_r));
      default: begin
        if (ctrl2.valid) begin
          col_nxt[ctrl2.col] = (ctrl2.kind == K_MAC) ? (col_r[ctrl2.col] + term) : term;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      iter_r  <= '0;
      pc_r    <= '0;
      op_r    <= '0;
      final_r <= 1'b0;
      q_r     <= '0;
      ctrl1_r <= '0;
      for (int n = 0; n < NUM_LIMBS; n++) begin
        col_r[n] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      iter_r  <= iter_nxt;
      pc_r    <= pc_nxt;
      op_r    <= op_nxt;
      final_r <= final_nxt;
      q_r     <= q_nxt;
      ctrl1_r <= ctrl0;
      for (int n = 0; n < NUM_LIMBS; n++) begin
        col_r[n] <= col_nxt[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    small_r <= small_nxt;
    if (in_accept && in_data.opcode == OP_LOAD_A) begin
      opa_r[in_data.word_index] <= in_data.data_word;
    end
    if (in_accept && in_data.opcode == OP_LOAD_B) begin
      opb_r[in_data.word_index] <= in_data.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdx_r <= mem_r[raddr_x];
    rdy_r <= mem_r[raddr_y];
  end

  c25fa_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (ctrl1_r),
    .x_i     (rdx_r),
    .y_i     (rdy_r),
    .small_i (small_r),
    .ctrl_o  (ctrl2),
    .term_o  (term)
  );

`ifndef SYNTH
  a_last_beat_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_word) |=> !busy)
    else $error("unit still busy after the last result beat");

  a_beats_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_index == 2'd0) |=>
    (out_valid && out_data.result_index == 2'd1))
    else $error("result beats not consecutive");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_is_zero) |-> (out_data.result_word == 64'd0))
    else $error("zero flag set on a nonzero word");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.opcode == OP_LOAD_A || in_data.opcode == OP_LOAD_B))
    |=> !busy)
    else $error("operand load made the unit busy");

  a_no_beat_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");
`endif

endmodule

`default_nettype wire

[test/c25fa_checker.sv]
// ----------------------------------------------------------------------------
// c25fa_checker: result predictor and scoreboard for the field arithmetic unit
// Watches accepted command beats, keeps a copy of both operands, computes each
// run as a value modulo 2^255-19 and compares every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c25fa_checker
  import c25fa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        runs_seen,
  output int        chains_seen,
  output int        beats_seen
);

  localparam logic [255:0] PRIME = (256'd1 << 255) - 256'd19;

  logic [63:0] opa [4];
  logic [63:0] opb [4];
  out_item_t   expected_beats [$];

  function automatic logic [255:0] reduce_operand(input logic [63:0] w [4]);
    logic [255:0] v;
    v = {1'b0, w[3][62:0], w[2], w[1], w[0]};
    if (v >= PRIME) begin
      v = v - PRIME;
    end
    return v;
  endfunction

  function automatic logic [255:0] mod_mul(input logic [255:0] x, input logic [255:0] y);
    logic [511:0] t;
    t = {256'd0, x} * {256'd0, y};
    t = t % {256'd0, PRIME};
    return t[255:0];
  endfunction

  function automatic logic [255:0] mod_pow(input logic [255:0] x, input logic [255:0] e);
    logic [255:0] acc;
    acc = 256'd1;
    for (int i = 255; i >= 0; i--) begin
      acc = mod_mul(acc, acc);
      if (e[i]) begin
        acc = mod_mul(acc, x);
      end
    end
    return acc;
  endfunction

  function automatic logic [255:0] field_result(input logic [3:0] op, input logic [255:0] a,
                                                input logic [255:0] b, input logic [31:0] k,
                                                input logic sel);
    logic [256:0] s;
    logic [255:0] r;
    case (op)
      OP_MUL:       r = mod_mul(a, b);
      OP_SQUARE:    r = mod_mul(a, a);
      OP_ADD: begin
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME}) begin
          s = s - {1'b0, PRIME};
        end
        r = s[255:0];
      end
      OP_SUB:       r = (a >= b) ? a - b : a + PRIME - b;
      OP_NEG:       r = (a == 256'd0) ? 256'd0 : PRIME - a;
      OP_MUL_SMALL: r = mod_mul(a, {224'd0, k});
      OP_INVERT:    r = mod_pow(a, PRIME - 256'd2);
      OP_POW22523:  r = mod_pow(a, (256'd1 << 252) - 256'd3);
      OP_SELECT:    r = sel ? b : a;
      default:      r = a;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    logic [255:0] r;
    out_item_t    e;
    if (rst_n && start && !busy) begin
      case (in_data.opcode)
        OP_LOAD_A: opa[in_data.word_index] = in_data.data_word;
        OP_LOAD_B: opb[in_data.word_index] = in_data.data_word;
        OP_MUL, OP_SQUARE, OP_ADD, OP_SUB, OP_NEG, OP_MUL_SMALL,
        OP_INVERT, OP_POW22523, OP_SELECT, OP_CANON: begin
          r = field_result(in_data.opcode, reduce_operand(opa), reduce_operand(opb),
                           in_data.small_factor, in_data.select_bit);
          runs_seen++;
          if (in_data.opcode == OP_INVERT || in_data.opcode == OP_POW22523) begin
            chains_seen++;
          end
          for (int i = 0; i < 4; i++) begin
            e.result_word        = r[64*i +: 64];
            e.result_index       = 2'(i);
            e.last_word          = (i == 3);
            e.result_is_zero     = (r == 256'd0);
            e.result_is_negative = r[0];
            expected_beats.push_back(e);
          end
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result beat with nothing expected: %h", $realtime, out_data);
        end
      end else begin
        e = expected_beats.pop_front();
        if (out_data.result_word !== e.result_word) begin
          report("result_word", e.result_word, out_data.result_word);
        end
        if (out_data.result_index !== e.result_index) begin
          report("result_index", 64'(e.result_index), 64'(out_data.result_index));
        end
        if (out_data.last_word !== e.last_word) begin
          report("last_word", 64'(e.last_word), 64'(out_data.last_word));
        end
        if (out_data.result_is_zero !== e.result_is_zero) begin
          report("result_is_zero", 64'(e.result_is_zero), 64'(out_data.result_is_zero));
        end
        if (out_data.result_is_negative !== e.result_is_negative) begin
          report("result_is_negative", 64'(e.result_is_negative),
                 64'(out_data.result_is_negative));
        end
      end
    end
    pending <= expected_beats.size();
  end

  initial begin
    fail_count  = 0;
    pending     = 0;
    runs_seen   = 0;
    chains_seen = 0;
    beats_seen  = 0;
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: regression bench for the curve25519 field arithmetic unit
// Loads operands word by word, runs every field operation on directed edge
// values and on random operands with random gaps, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import c25fa_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        runs_seen;
  int        chains_seen;
  int        beats_seen;
  int        items_sent;
  int        idle_cycles;

  curve25519_field_arith_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  c25fa_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .runs_seen  (runs_seen),
    .chains_seen(chains_seen),
    .beats_seen (beats_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic issue(input logic [3:0] op, input logic [1:0] idx, input logic [63:0] w,
                       input logic [31:0] k, input logic sel);
    logic [127:0] noise;
    in_data.opcode       = op;
    in_data.word_index   = idx;
    in_data.data_word    = w;
    in_data.small_factor = k;
    in_data.select_bit   = sel;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    if ($urandom_range(0, 3) == 0) begin
      start = 1'b0;
      noise = {$urandom, $urandom, $urandom, $urandom};
      in_data = noise[$bits(in_item_t)-1:0];
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic load_operand(input logic [3:0] op, input logic [255:0] v);
    for (int i = 0; i < 4; i++) begin
      issue(op, 2'(i), v[64*i +: 64], $urandom, 1'($urandom));
    end
  endtask

  function automatic logic [63:0] rand_word(input logic [1:0] idx);
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0:       w = 64'd0;
      1:       w = '1;
      2:       w = 64'($urandom_range(0, 40));
      3:       w = (idx == 2'd0) ? 64'hFFFF_FFFF_FFFF_FFED : '1;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] rand_run_op();
    logic [3:0] ops [8];
    ops = '{OP_MUL, OP_SQUARE, OP_ADD, OP_SUB, OP_NEG, OP_MUL_SMALL, OP_SELECT, OP_CANON};
    if ($urandom_range(0, 99) < 3) begin
      return ($urandom_range(0, 1) != 0) ? OP_INVERT : OP_POW22523;
    end
    return ops[$urandom_range(0, 7)];
  endfunction

  initial begin
    logic [255:0] prime;
    logic [31:0]  k;
    logic [3:0]   op;
    int           drain_at;
    prime       = (256'd1 << 255) - 256'd19;
    start       = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    drain_at    = 97;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_operand(OP_LOAD_A, prime - 256'd1);
    load_operand(OP_LOAD_B, '1);
    issue(OP_MUL, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_ADD, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_SUB, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_MUL_SMALL, 2'd0, 64'd0, 32'hFFFF_FFFF, 1'b0);
    issue(OP_SELECT, 2'd0, 64'd0, 32'd0, 1'b1);
    issue(OP_SELECT, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(4'd13, 2'd3, '1, '1, 1'b1);
    load_operand(OP_LOAD_A, prime + 256'd5);
    issue(OP_CANON, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_SQUARE, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_POW22523, 2'd0, 64'd0, 32'd0, 1'b0);
    load_operand(OP_LOAD_A, 256'd0);
    issue(OP_INVERT, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_NEG, 2'd0, 64'd0, 32'd0, 1'b0);
    issue(OP_MUL_SMALL, 2'd0, 64'd0, 32'd0, 1'b0);

    while (items_sent < 480) begin
      if ($urandom_range(0, 99) < 85) begin
        repeat ($urandom_range(0, 4)) begin
          k = $urandom_range(0, 3);
          op = ($urandom_range(0, 1) != 0) ? OP_LOAD_B : OP_LOAD_A;
          issue(op, 2'(k), rand_word(2'(k)), $urandom, 1'($urandom));
        end
        issue(rand_run_op(), 2'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom));
      end else if ($urandom_range(0, 1) != 0) begin
        issue(4'($urandom_range(12, 15)), 2'($urandom), {$urandom, $urandom},
              $urandom, 1'($urandom));
      end else begin
        k = $urandom_range(0, 3);
        issue(OP_LOAD_A, 2'(k), rand_word(2'(k)), $urandom, 1'($urandom));
      end
      if (items_sent >= drain_at) begin
        while (pending != 0) @(negedge clk);
        drain_at += 97;
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d field operations (%0d exponent chains) in %0d command beats;",
             runs_seen, chains_seen, items_sent);
    $display("checked %0d result beats.", beats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/c25fa_pkg.sv
src/c25fa_mac.sv
src/curve25519_field_arith_unit.sv
test/c25fa_checker.sv
test/tb_top.sv
